// ===== rtl/ttsl_pkg.sv =====
`timescale 1ns / 1ps
// Package for the template-to-string-literal filter: beat types, the command
// passed from front to back, character constants and the line-close table.
// No dependencies.
package ttsl_pkg;

	// Characters the filter recognizes or emits.
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_OPEN   = 8'h7B;
	localparam logic [7:0] CH_CLOSE  = 8'h7D;

	// Length of the sequence that closes a literal at a line end.
	localparam int unsigned CLOSE_LEN = 9;

	// Command queue between front and back.
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// Position inside one emit unit; a unit holds at most CLOSE_LEN + 1 bytes.
	localparam int unsigned POS_W = $clog2(CLOSE_LEN + 1);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	// One emit unit: optional close sequence or opening quote, optional
	// escape, then the character itself.
	typedef struct packed {
		logic       en;
		logic       quote;
		logic       crlf;
		logic       esc;
		logic [7:0] ch;
	} unit_t;

	// One command: unit a always present, unit b follows when enabled.
	typedef struct packed {
		unit_t a;
		unit_t b;
	} cmd_t;

	// Bytes of the escaped CR LF and closing quote.
	function automatic logic [7:0] close_byte(input logic [POS_W-1:0] idx);
		logic [7:0] b;
		case (idx)
			POS_W'(0): b = CH_BSLASH;
			POS_W'(1): b = 8'h30;
			POS_W'(2): b = 8'h31;
			POS_W'(3): b = 8'h35;
			POS_W'(4): b = CH_BSLASH;
			POS_W'(5): b = 8'h30;
			POS_W'(6): b = 8'h31;
			POS_W'(7): b = 8'h32;
			default:   b = CH_QUOTE;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/ttsl_front.sv =====
`timescale 1ns / 1ps
// Front end: matches delimiters, tracks code/text mode and literal state,
// and turns each accepted byte into a command. Depends on ttsl_pkg.
module ttsl_front import ttsl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_item_t item,
	output logic     push,
	output cmd_t     cmd
);

	logic pend_q, code_q, sc_q;
	logic pend, code, sc_a, sc_b, sc_n, code_n, pend_n;
	logic [7:0] delim;
	unit_t ua, ub;

	// One byte in text mode, given whether a literal is closed.
	function automatic unit_t text_unit(input logic [7:0] b, input logic sc,
			output logic sc_out);
		unit_t u;
		u.en = 1'b1;
		u.ch = b;
		if (b == CH_LF || b == CH_CR) begin
			u.quote = 1'b0;
			u.crlf  = !sc;
			u.esc   = 1'b0;
			sc_out  = 1'b1;
		end else begin
			u.quote = sc;
			u.crlf  = 1'b0;
			u.esc   = (b == CH_QUOTE) || (b == CH_BSLASH);
			sc_out  = 1'b0;
		end
		return u;
	endfunction

	function automatic unit_t mode_unit(input logic [7:0] b, input logic cm,
			input logic sc, output logic sc_out);
		unit_t u;
		if (cm) begin
			u = '{en: 1'b1, quote: 1'b0, crlf: 1'b0, esc: 1'b0, ch: b};
			sc_out = sc;
		end else begin
			u = text_unit(b, sc, sc_out);
		end
		return u;
	endfunction

	always_comb begin
		pend   = item.file_start ? 1'b0 : pend_q;
		code   = item.file_start ? 1'b1 : code_q;
		delim  = code ? CH_OPEN : CH_CLOSE;
		ua     = '0;
		ub     = '0;
		sc_a   = sc_q;
		sc_b   = sc_q;
		sc_n   = sc_q;
		code_n = code;
		pend_n = 1'b0;
		push   = 1'b0;
		if (item.data_byte == delim) begin
			if (!pend) begin
				pend_n = 1'b1;
			end else begin
				push = accept;
				if (code) begin
					code_n = 1'b0;
					sc_n   = 1'b1;
					ua     = '{en: 1'b1, quote: 1'b0, crlf: 1'b0, esc: 1'b0, ch: CH_SPACE};
				end else begin
					code_n = 1'b1;
					ua     = '{en: 1'b1, quote: !sc_q, crlf: 1'b0, esc: 1'b0, ch: CH_SPACE};
				end
			end
		end else begin
			push = accept;
			if (pend) begin
				ua   = mode_unit(delim, code, sc_q, sc_a);
				ub   = mode_unit(item.data_byte, code, sc_a, sc_b);
				sc_n = sc_b;
			end else begin
				ua   = mode_unit(item.data_byte, code, sc_q, sc_a);
				sc_n = sc_a;
			end
		end
		cmd.a = ua;
		cmd.b = ub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			code_q <= 1'b1;
			sc_q   <= 1'b1;
		end else if (accept) begin
			pend_q <= pend_n;
			code_q <= code_n;
			sc_q   <= sc_n;
		end
	end

	// A held delimiter byte only exists while matching is in progress.
	a_push_clears_pend: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> !pend_q) else $error("pending delimiter left set by a command");
	a_text_quote: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !code && cmd.a.quote && cmd.a.ch != CH_SPACE) |-> sc_q)
		else $error("opening quote while a literal is open");
	a_code_plain: assert property (@(posedge clk) disable iff (!arst_n)
		(push && code && !code_n) |-> (cmd.a.ch == CH_SPACE && !cmd.b.en))
		else $error("entering text must emit a lone space");

endmodule

// ===== rtl/ttsl_queue.sv =====
`timescale 1ns / 1ps
// Command queue between front and back: a small register FIFO.
// Depends on ttsl_pkg.
module ttsl_queue import ttsl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	input  logic pop,
	output logic full,
	output logic nonempty,
	output cmd_t rdata
);

	cmd_t              mem [QDEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] nxt(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	assign full     = (count_q == QCNT_W'(QDEPTH));
	assign nonempty = (count_q != '0);
	assign rdata    = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= nxt(wptr_q);
			end
			if (pop) begin
				rptr_q <= nxt(rptr_q);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("command queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty) else $error("command queue underflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH)) else $error("command count out of range");

endmodule

// ===== rtl/ttsl_back.sv =====
`timescale 1ns / 1ps
// Back end: expands the head command into output bytes, one per cycle while
// lit_stall allows, through an output register. Depends on ttsl_pkg.
module ttsl_back import ttsl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  cmd_t      head,
	output logic      pop,
	output logic      lit_valid,
	input  logic      lit_stall,
	output out_item_t lit
);

	logic             sel_q;
	logic [POS_W-1:0] pos_q;
	logic             valid_q;
	out_item_t        lit_q;

	unit_t            u;
	logic [POS_W-1:0] len;
	logic [7:0]       ch;
	logic             unit_last, cmd_last, take;

	always_comb begin
		u   = sel_q ? head.b : head.a;
		len = POS_W'(1) + (u.crlf ? POS_W'(CLOSE_LEN) : '0)
			+ POS_W'(u.quote) + POS_W'(u.esc);
		if (u.crlf) begin
			ch = (pos_q < POS_W'(CLOSE_LEN)) ? close_byte(pos_q) : u.ch;
		end else if (u.quote && pos_q == '0) begin
			ch = CH_QUOTE;
		end else if (u.esc && pos_q == POS_W'(u.quote)) begin
			ch = CH_BSLASH;
		end else begin
			ch = u.ch;
		end
		unit_last = (pos_q == len - POS_W'(1));
		cmd_last  = unit_last && (sel_q || !head.b.en);
		take      = head_valid && (!valid_q || !lit_stall);
		pop       = take && cmd_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q   <= 1'b0;
			pos_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (!valid_q || !lit_stall) begin
				valid_q <= head_valid;
			end
			if (take) begin
				if (unit_last) begin
					pos_q <= '0;
					sel_q <= !cmd_last;
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			lit_q <= '{out_byte: ch, last_of_run: cmd_last};
		end
	end

	assign lit_valid = valid_q;
	assign lit       = lit_q;

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> pos_q < len) else $error("unit position past its end");
	a_sel_b_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && sel_q) |-> head.b.en) else $error("second unit selected but absent");
	a_pop_resets: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (!sel_q && pos_q == '0)) else $error("sequencer not rewound after command");

endmodule

// ===== rtl/template_to_string_literal_filter.sv =====
`timescale 1ns / 1ps
// Top level of the template-to-string-literal filter: front end, command
// queue and back end. Depends on ttsl_pkg, ttsl_front, ttsl_queue, ttsl_back.
//
//   channel | valid      | stall      | beat                    | direction
//   tmpl    | tmpl_valid | tmpl_stall | in_item_t  (data, start) | into block
//   lit     | lit_valid  | lit_stall  | out_item_t (byte, last)  | out of block
//
// The front end accepts one template byte per cycle while the queue has room
// and classifies it in the same cycle; the back end sends one output byte per
// cycle while lit_stall is low, so a byte that yields one output flows at one
// beat per cycle. A byte that yields n outputs (up to twelve) holds the back
// end until all n have gone; a delimiter start yields none. The command queue
// holds four entries, and tmpl_stall rises only while it is full. Outputs pass
// through the command queue and then leave through an output register. Reset
// clears the mode and queue state; there is no clearing pass.
module template_to_string_literal_filter import ttsl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      tmpl_valid,
	output logic      tmpl_stall,
	input  in_item_t  tmpl,
	output logic      lit_valid,
	input  logic      lit_stall,
	output out_item_t lit
);

	logic accept, push, pop, full, nonempty;
	cmd_t cmd, head;

	// A beat is taken whenever the queue has room, even while the back end
	// is still working through a long run.
	assign tmpl_stall = full;
	assign accept     = tmpl_valid && !full;

	// Front end: delimiter matching and escaping decisions.
	ttsl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (tmpl),
		.push   (push),
		.cmd    (cmd)
	);

	// Queue that lets the front run ahead of a stalled or busy back end.
	ttsl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (cmd),
		.pop      (pop),
		.full     (full),
		.nonempty (nonempty),
		.rdata    (head)
	);

	// Back end: byte-by-byte expansion of each command.
	ttsl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (nonempty),
		.head       (head),
		.pop        (pop),
		.lit_valid  (lit_valid),
		.lit_stall  (lit_stall),
		.lit        (lit)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for template_to_string_literal_filter: a queue-fed
// driver, a monitor and a byte-level predictor of the literal rewriting.
// Depends on ttsl_pkg and the filter RTL.
module tb_top;
	import ttsl_pkg::*;

	// A hung block shows up as a long run of cycles with no beat on either
	// channel. The slowest correct run never gets near this.
	localparam int unsigned IDLE_LIMIT   = 4000;
	// Once nothing is expected, wait this long to catch stray beats.
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned MAX_SHOWN    = 10;
	localparam int unsigned DIRECTED_N   = 24;
	localparam int unsigned RANDOM_N     = 136;
	// Items per idling phase; phases rotate through the whole stimulus.
	localparam int unsigned PHASE_LEN    = 40;

	// Escaped CR LF followed by the closing quote, first byte in the top lane.
	localparam logic [CLOSE_LEN*8-1:0] LINE_CLOSE = {CH_BSLASH, 8'h30, 8'h31, 8'h35,
		CH_BSLASH, 8'h30, 8'h31, 8'h32, CH_QUOTE};

	// One pending template byte together with the idling that applies while
	// it is sent. A set hold_until_empty makes the sender wait until every
	// expected output has come before this beat goes out.
	typedef struct {
		in_item_t    beat;
		int unsigned gap_pct;
		int unsigned stall_pct;
		bit          hold_until_empty;
	} pending_byte_t;

	logic      clk        = 1'b0;
	logic      arst_n     = 1'b0;
	logic      tmpl_valid = 1'b0;
	logic      tmpl_stall;
	in_item_t  tmpl       = '0;
	logic      lit_valid;
	logic      lit_stall  = 1'b0;
	out_item_t lit;

	template_to_string_literal_filter u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.tmpl_valid (tmpl_valid),
		.tmpl_stall (tmpl_stall),
		.tmpl       (tmpl),
		.lit_valid  (lit_valid),
		.lit_stall  (lit_stall),
		.lit        (lit)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Filter state as the predictor sees it. Reset is applied once at the
	// start, so the reset values are simply the initial values here.
	logic held_delim = 1'b0;
	logic code_mode  = 1'b1;
	logic lit_closed = 1'b1;

	pending_byte_t template_bytes[$];
	out_item_t     literal_expected[$];
	logic [7:0]    run_bytes[$];

	int unsigned queued_n    = 0;
	int unsigned stall_pct   = 0;
	int unsigned mismatches  = 0;
	int unsigned idle_cycles = 0;

	// Appends the bytes that one character turns into, given the current mode.
	// In text mode a line end closes an open literal first, and any other
	// character opens a literal when none is open.
	task automatic emit_char(input logic [7:0] ch);
		int i;
		if (code_mode) begin
			run_bytes.push_back(ch);
		end else if (ch == CH_CR || ch == CH_LF) begin
			if (!lit_closed)
				for (i = 0; i < CLOSE_LEN; i++)
					run_bytes.push_back(LINE_CLOSE[(CLOSE_LEN-1-i)*8 +: 8]);
			run_bytes.push_back(ch);
			lit_closed = 1'b1;
		end else begin
			if (lit_closed) begin
				run_bytes.push_back(CH_QUOTE);
				lit_closed = 1'b0;
			end
			if (ch == CH_QUOTE || ch == CH_BSLASH)
				run_bytes.push_back(CH_BSLASH);
			run_bytes.push_back(ch);
		end
	endtask

	// Works out every output byte caused by one accepted template byte and
	// queues them, marking the final one as the last of the run.
	task automatic predict_literal(input in_item_t b);
		logic [7:0] delim;
		run_bytes.delete();
		if (b.file_start) begin
			held_delim = 1'b0;
			code_mode  = 1'b1;
		end
		delim = code_mode ? CH_OPEN : CH_CLOSE;
		if (b.data_byte == delim) begin
			if (!held_delim) begin
				// First half of a delimiter is held back and emits nothing.
				held_delim = 1'b1;
			end else begin
				held_delim = 1'b0;
				if (code_mode) begin
					code_mode  = 1'b0;
					lit_closed = 1'b1;
				end else begin
					code_mode = 1'b1;
					if (!lit_closed)
						run_bytes.push_back(CH_QUOTE);
				end
				run_bytes.push_back(CH_SPACE);
			end
		end else begin
			// A broken delimiter flushes the held byte before this one, and
			// this byte is not taken as a new delimiter start.
			if (held_delim) begin
				emit_char(delim);
				held_delim = 1'b0;
			end
			emit_char(b.data_byte);
		end
		foreach (run_bytes[k])
			literal_expected.push_back('{out_byte: run_bytes[k],
				last_of_run: (k == run_bytes.size() - 1)});
	endtask

	// Queues one template byte. Its idling phase follows from its position
	// in the stimulus: no idling, sender gaps, receiver stalls, then both.
	// A few positions also ask the sender to wait for a fully drained block.
	task automatic queue_byte(input logic [7:0] data, input logic fs);
		pending_byte_t p;
		p.beat             = '{data_byte: data, file_start: fs};
		p.hold_until_empty = (queued_n % 60 == 30);
		case ((queued_n / PHASE_LEN) % 4)
			0:       begin p.gap_pct = 0;  p.stall_pct = 0;  end
			1:       begin p.gap_pct = 45; p.stall_pct = 0;  end
			2:       begin p.gap_pct = 0;  p.stall_pct = 45; end
			default: begin p.gap_pct = 29; p.stall_pct = 29; end
		endcase
		template_bytes.push_back(p);
		queued_n++;
	endtask

	// Characters with a meaning somewhere in the filter turn up far more
	// often than in plain random bytes.
	function automatic logic [7:0] template_char();
		case ($urandom_range(9))
			0:       return CH_QUOTE;
			1:       return CH_BSLASH;
			2:       return CH_CR;
			3:       return CH_LF;
			4:       return CH_OPEN;
			5:       return CH_CLOSE;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Driver. A beat that is accepted here goes to the predictor. The next
	// beat is loaded only when the channel is free, so a stalled payload
	// stays put and valid never looks at stall.
	always @(posedge clk) begin
		if (arst_n) begin
			if (tmpl_valid && !tmpl_stall)
				predict_literal(tmpl);
			if (!tmpl_valid || !tmpl_stall) begin
				if (template_bytes.size() != 0 &&
					!(template_bytes[0].hold_until_empty && literal_expected.size() != 0) &&
					$urandom_range(99) >= template_bytes[0].gap_pct) begin
					tmpl_valid <= 1'b1;
					tmpl       <= template_bytes[0].beat;
					stall_pct  <= template_bytes[0].stall_pct;
					void'(template_bytes.pop_front());
				end else begin
					tmpl_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Each accepted output beat is checked against the oldest
	// expected byte, field by field; a beat with nothing expected is an error.
	always @(posedge clk) begin : monitor
		out_item_t want;
		if (arst_n && lit_valid && !lit_stall) begin
			if (literal_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected output beat: byte %h last %b",
						lit.out_byte, lit.last_of_run);
			end else begin
				want = literal_expected.pop_front();
				if (lit.out_byte !== want.out_byte || lit.last_of_run !== want.last_of_run) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("output mismatch: byte %h last %b, expected byte %h last %b",
							lit.out_byte, lit.last_of_run, want.out_byte, want.last_of_run);
				end
			end
		end
		lit_stall <= ($urandom_range(99) < stall_pct);
	end

	// Counts cycles with no beat on either channel.
	always @(posedge clk) begin
		if ((tmpl_valid && !tmpl_stall) || (lit_valid && !lit_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("FAIL template_to_string_literal_filter");
		$finish;
	end

	initial begin
		int unsigned len;
		int unsigned k;

		// Directed part: extreme byte values in code mode, a broken opening
		// delimiter, entering text, escapes, a broken closing delimiter, line
		// ends with the literal open and closed, the twelve-byte worst case,
		// leaving text with an open literal, and file start
		// dropping a held delimiter byte in both modes.
		queue_byte(8'h00, 1'b1);
		queue_byte(8'hFF, 1'b0);
		queue_byte(CH_OPEN, 1'b0);
		queue_byte("A", 1'b0);
		queue_byte(CH_OPEN, 1'b0);
		queue_byte(CH_OPEN, 1'b0);
		queue_byte(CH_QUOTE, 1'b0);
		queue_byte(CH_BSLASH, 1'b0);
		queue_byte(CH_CLOSE, 1'b0);
		queue_byte("q", 1'b0);
		queue_byte(CH_CR, 1'b0);
		queue_byte(CH_LF, 1'b0);
		// Held close brace with no literal open, then CR: quote, brace, the
		// close sequence and the CR itself.
		queue_byte(CH_CLOSE, 1'b0);
		queue_byte(CH_CR, 1'b0);
		queue_byte(CH_OPEN, 1'b0);
		queue_byte(CH_CLOSE, 1'b0);
		queue_byte(CH_CLOSE, 1'b0);
		queue_byte(CH_OPEN, 1'b0);
		queue_byte(CH_OPEN, 1'b0);
		queue_byte(CH_CLOSE, 1'b0);
		queue_byte("a", 1'b1);
		queue_byte(CH_OPEN, 1'b0);
		queue_byte(CH_OPEN, 1'b1);
		queue_byte("b", 1'b0);

		// Random part: mostly well-formed code, open, text, close sequences
		// with random content, mixed with short runs of noise.
		while (queued_n < DIRECTED_N + RANDOM_N) begin
			if ($urandom_range(3) != 0) begin
				len = $urandom_range(3);
				for (k = 0; k < len; k++)
					queue_byte(8'($urandom_range(255)), $urandom_range(24) == 0);
				queue_byte(CH_OPEN, $urandom_range(24) == 0);
				queue_byte(CH_OPEN, 1'b0);
				len = $urandom_range(8, 1);
				for (k = 0; k < len; k++)
					queue_byte(template_char(), $urandom_range(40) == 0);
				queue_byte(CH_CLOSE, 1'b0);
				queue_byte(CH_CLOSE, 1'b0);
			end else begin
				len = $urandom_range(4, 1);
				for (k = 0; k < len; k++)
					queue_byte(template_char(), $urandom_range(12) == 0);
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (template_bytes.size() != 0 || tmpl_valid || literal_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && literal_expected.size() == 0)
			$display("PASS template_to_string_literal_filter");
		else
			$display("FAIL template_to_string_literal_filter");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ttsl_pkg.sv
rtl/ttsl_front.sv
rtl/ttsl_queue.sv
rtl/ttsl_back.sv
rtl/template_to_string_literal_filter.sv
tb/sv/tb_top.sv
